// File: design/permutation_power_transposition_unit_defines.svh
// assertion macros for the permutation power transposition unit
`ifndef PERMUTATION_POWER_TRANSPOSITION_UNIT_DEFINES_SVH
`define PERMUTATION_POWER_TRANSPOSITION_UNIT_DEFINES_SVH
// clocked implication with synchronous active-low reset
`define PPT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// holds in every cycle out of reset
`define PPT_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`endif

// File: design/ppt_pkg.sv
// shared types and constants for the permutation power transposition unit
package ppt_pkg;
  localparam int unsigned MaxLen = 64;
  localparam logic [7:0] SpaceChar = 8'h20;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_BYTE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // classified request from the front part
  typedef struct packed {
    op_t         op;
    logic [5:0]  position;
    logic [5:0]  target;
    logic [30:0] power;
    logic [7:0]  data;
    logic        last;
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_WALK_STEP,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_MOVE_READ,
    ST_MOVE_STEP,
    ST_MOVE_WRITE,
    ST_EMIT_READ,
    ST_EMIT_WAIT
  } state_t;
endpackage

// File: design/ppt_front.sv
// front part: accepts requests, drops unused codes and queues them for the back part
module ppt_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_op,
  input  logic [5:0]       in_position,
  input  logic [5:0]       in_target,
  input  logic [30:0]      in_power,
  input  logic [7:0]       in_byte_in,
  input  logic             in_last_in,
  output logic             q_valid,
  output ppt_pkg::req_t    q_req,
  input  logic             q_take
);
  localparam int unsigned Depth = ppt_pkg::QueueDepth;
  ppt_pkg::req_t mem_r [Depth];
  logic          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop, keep;
  ppt_pkg::req_t req;

  assign in_stall = (cnt_r == 2'(Depth));
  assign keep     = (in_op != ppt_pkg::OP_NONE);
  assign push     = in_valid && !in_stall && keep;
  assign pop      = q_take && q_valid;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];

  always_comb begin
    req.op       = ppt_pkg::op_t'(in_op);
    req.position = in_position;
    req.target   = in_target;
    req.power    = in_power;
    req.data     = in_byte_in;
    req.last     = in_last_in;
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= req;
  end
endmodule

// File: design/ppt_back.sv
// back part: permutation and message stores, cycle walk, power reduction, output
module ppt_back #(
  parameter int unsigned MAX_LEN = ppt_pkg::MaxLen
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [6:0]    len,
  input  logic          q_valid,
  input  ppt_pkg::req_t q_req,
  output logic          q_take,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte_out,
  output logic [5:0]    out_out_position,
  output logic          out_last_out
);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [5:0] perm_mem [MAX_LEN];
  logic [7:0] msg_mem  [MAX_LEN];
  logic [7:0] res_mem  [MAX_LEN];

  ppt_pkg::state_t st_r, st_nxt;
  logic [6:0]  cnt_r, cnt_nxt;     // byte_count
  logic [30:0] pw_r, pw_nxt;
  logic [6:0]  i_r, i_nxt;         // source position
  logic [5:0]  cur_r, cur_nxt;
  logic [6:0]  s_r, s_nxt;         // step count / cycle length
  logic [6:0]  steps_r, steps_nxt;
  logic [30:0] rem_r, rem_nxt;     // restoring division remainder
  logic [4:0]  bit_r, bit_nxt;
  logic [7:0]  mb_r;

  logic [5:0]  pt_r;
  logic [5:0]  nx;
  logic [31:0] trial;
  logic        obuf_v_r, obuf_v_nxt;
  logic [7:0]  ob_r;
  logic        ob_ld;
  logic [5:0]  op_r, op_nxt;
  logic        ol_r, ol_nxt;
  logic        res_we, msg_we, perm_we;
  logic [AW-1:0] res_wa, msg_wa;
  logic [7:0]  res_wd, msg_wd;

  assign nx = ({1'b0, pt_r} < len) ? pt_r : cur_r;
  assign trial = {rem_r, pw_r[bit_r]} - {25'd0, s_r};
  assign out_valid = obuf_v_r;
  assign out_byte_out = ob_r;
  assign out_out_position = op_r;
  assign out_last_out = ol_r;
  assign perm_we = (st_r == ppt_pkg::ST_IDLE) && q_valid && q_req.op == ppt_pkg::OP_LOAD
                   && (32'(q_req.position) < MAX_LEN);

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; pw_nxt = pw_r; i_nxt = i_r; cur_nxt = cur_r;
    s_nxt = s_r; steps_nxt = steps_r; rem_nxt = rem_r; bit_nxt = bit_r;
    obuf_v_nxt = obuf_v_r && out_stall; ob_ld = 1'b0; op_nxt = op_r; ol_nxt = ol_r;
    q_take = 1'b0;
    res_we = 1'b0; res_wa = i_r[AW-1:0]; res_wd = ppt_pkg::SpaceChar;
    msg_we = 1'b0; msg_wa = cnt_r[AW-1:0]; msg_wd = q_req.data;
    unique case (st_r)
      ppt_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          unique case (q_req.op)
            ppt_pkg::OP_START: begin
              pw_nxt = q_req.power;
              cnt_nxt = 7'd0;
            end
            ppt_pkg::OP_BYTE: begin
              if (cnt_r < len) begin
                msg_we = 1'b1;
                cnt_nxt = cnt_r + 7'd1;
              end
              if (q_req.last) begin
                st_nxt = ppt_pkg::ST_FILL;
                i_nxt = 7'd0;
              end
            end
            default: ;
          endcase
        end
      end
      // pad message tail and clear the result store
      ppt_pkg::ST_FILL: begin
        res_we = 1'b1;
        if (i_r >= cnt_r) begin
          msg_we = 1'b1; msg_wa = i_r[AW-1:0]; msg_wd = ppt_pkg::SpaceChar;
        end
        if (i_r + 7'd1 == len) begin
          st_nxt = ppt_pkg::ST_WALK_STEP;
          cnt_nxt = 7'd0;
          i_nxt = 7'd0;
          cur_nxt = 6'd0;
          s_nxt = 7'd1;
        end else begin
          i_nxt = i_r + 7'd1;
        end
      end
      // walk from i until it returns, counting the cycle length
      ppt_pkg::ST_WALK_STEP: begin
        cur_nxt = nx;
        if (nx == i_r[5:0]) begin
          st_nxt = ppt_pkg::ST_DIV_INIT;
        end else if (s_r == len) begin
          s_nxt = 7'd0;
          st_nxt = ppt_pkg::ST_DIV_INIT;
        end else begin
          s_nxt = s_r + 7'd1;
        end
      end
      ppt_pkg::ST_DIV_INIT: begin
        rem_nxt = 31'd0;
        bit_nxt = 5'd30;
        if (s_r == 7'd0) begin
          steps_nxt = 7'd0;
          st_nxt = ppt_pkg::ST_MOVE_READ;
        end else begin
          st_nxt = ppt_pkg::ST_DIV_RUN;
        end
      end
      // one remainder bit per cycle
      ppt_pkg::ST_DIV_RUN: begin
        if (!trial[31]) rem_nxt = trial[30:0];
        else rem_nxt = {rem_r[29:0], pw_r[bit_r]};
        if (bit_r == 5'd0) begin
          st_nxt = ppt_pkg::ST_MOVE_READ;
          steps_nxt = (!trial[31]) ? trial[6:0] : {rem_r[5:0], pw_r[0]};
        end else begin
          bit_nxt = bit_r - 5'd1;
        end
      end
      ppt_pkg::ST_MOVE_READ: begin
        cur_nxt = i_r[5:0];
        st_nxt = (steps_r == 7'd0) ? ppt_pkg::ST_MOVE_WRITE : ppt_pkg::ST_MOVE_STEP;
      end
      ppt_pkg::ST_MOVE_STEP: begin
        cur_nxt = nx;
        steps_nxt = steps_r - 7'd1;
        if (steps_r == 7'd1) st_nxt = ppt_pkg::ST_MOVE_WRITE;
      end
      ppt_pkg::ST_MOVE_WRITE: begin
        res_we = 1'b1; res_wa = cur_r[AW-1:0]; res_wd = mb_r;
        if (i_r + 7'd1 == len) begin
          i_nxt = 7'd0;
          st_nxt = ppt_pkg::ST_EMIT_READ;
        end else begin
          i_nxt = i_r + 7'd1;
          cur_nxt = i_nxt[5:0];
          s_nxt = 7'd1;
          st_nxt = ppt_pkg::ST_WALK_STEP;
        end
      end
      ppt_pkg::ST_EMIT_READ: begin
        if (!obuf_v_nxt) begin
          obuf_v_nxt = 1'b1;
          ob_ld = 1'b1;
          op_nxt = i_r[5:0];
          ol_nxt = (i_r + 7'd1 == len);
          if (i_r + 7'd1 == len) st_nxt = ppt_pkg::ST_EMIT_WAIT;
          else i_nxt = i_r + 7'd1;
        end
      end
      ppt_pkg::ST_EMIT_WAIT: begin
        st_nxt = ppt_pkg::ST_IDLE;
      end
      default: st_nxt = ppt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ppt_pkg::ST_IDLE;
      cnt_r <= 7'd0;
      pw_r <= 31'd0;
      obuf_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      pw_r <= pw_nxt;
      obuf_v_r <= obuf_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; cur_r <= cur_nxt; s_r <= s_nxt; steps_r <= steps_nxt;
    rem_r <= rem_nxt; bit_r <= bit_nxt;
    op_r <= op_nxt; ol_r <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (perm_we) perm_mem[q_req.position[AW-1:0]] <= q_req.target;
    if (msg_we) msg_mem[msg_wa] <= msg_wd;
    if (res_we) res_mem[res_wa] <= res_wd;
    // table read follows the next walk address so pt_r matches cur_r
    pt_r <= perm_mem[cur_nxt[AW-1:0]];
    if (st_r == ppt_pkg::ST_MOVE_READ) mb_r <= msg_mem[i_r[AW-1:0]];
    if (ob_ld) ob_r <= res_mem[i_r[AW-1:0]];
  end
endmodule

// File: design/permutation_power_transposition_unit.sv
// top level of the permutation power transposition unit
// load, start and byte requests are taken one per cycle while the front queue is not full;
// the back part takes them from the queue only while idle. a last byte fills all len positions,
// then per position a walk of up to len steps, a restoring division of the power by the cycle
// length, a read, up to len-1 move steps and a write, then len outputs, via the single walk unit
// synchronous active-low reset clears control, byte count, power and length (MAX_LEN, 64 by default)
`include "permutation_power_transposition_unit_defines.svh"
module permutation_power_transposition_unit #(
  parameter int unsigned MAX_LEN = ppt_pkg::MaxLen
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [5:0]  in_position,
  input  logic [5:0]  in_target,
  input  logic [30:0] in_power,
  input  logic [7:0]  in_byte_in,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte_out,
  output logic [5:0]  out_out_position,
  output logic        out_last_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_length_in_use
);
  logic [6:0]    len_r, len_nxt;
  logic          q_valid, q_take;
  ppt_pkg::req_t q_req;

  assign cfg_ready = 1'b1;

  always_comb begin
    len_nxt = len_r;
    if (cfg_valid) begin
      if (cfg_length_in_use == 7'd0) len_nxt = 7'd1;
      else if (32'(cfg_length_in_use) > MAX_LEN) len_nxt = 7'(MAX_LEN);
      else len_nxt = cfg_length_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) len_r <= 7'(MAX_LEN);
    else len_r <= len_nxt;
  end

  ppt_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_position, .in_target,
    .in_power, .in_byte_in, .in_last_in, .q_valid, .q_req, .q_take
  );

  ppt_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk, .rst_n, .len(len_r), .q_valid, .q_req, .q_take,
    .out_valid, .out_stall, .out_byte_out, .out_out_position, .out_last_out
  );

  `PPT_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_out_position), "result dropped while stalled")
  `PPT_ASSERT_ALWAYS(a_len_range, clk, rst_n, len_r != 7'd0 && 32'(len_r) <= MAX_LEN, "length out of range")
  `PPT_ASSERT(a_last_pos, clk, rst_n, out_valid && out_last_out |-> out_out_position == 6'(len_r - 7'd1), "last mark misplaced")
endmodule
